// ----- design/mfk_pkg.sv -----
package mfk_pkg;

  localparam int SPEED_BITS  = 16;
  localparam int LENGTH_BITS = 16;

  // wheel-speed sums and their products with the radius
  localparam int SUM_W   = SPEED_BITS + 2;
  localparam int MAG_W   = SUM_W + LENGTH_BITS;
  localparam int CAP_W   = 39;
  localparam int EXT_W   = MAG_W + CAP_W + 1;

  // pi in q23
  localparam int PI_W = 25;
  localparam logic [PI_W-1:0] PI_Q23 = 25'd26353589;

  // partial products of the pi multiply
  localparam int SPLIT  = 20;
  localparam int LO_W   = SPLIT + PI_W;
  localparam int HI_W   = CAP_W - SPLIT + PI_W;
  localparam int PROD_W = 64;

  // spacing sum, divider and root widths
  localparam int SPC_W  = LENGTH_BITS + 1;
  localparam int DEN_W  = SPC_W + 15;
  localparam int QUO_W  = 32;
  localparam int DIV_W  = DEN_W + QUO_W;
  localparam int WIDE_W = (DIV_W > PROD_W) ? DIV_W : PROD_W;
  localparam int STAGES = 32;

  localparam int CFG_IDX_W  = 2;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  localparam logic [LENGTH_BITS-1:0] RADIUS_RST = LENGTH_BITS'(3277);
  localparam logic [LENGTH_BITS-1:0] SIDE_RST   = LENGTH_BITS'(19661);
  localparam logic [LENGTH_BITS-1:0] AXLE_RST   = LENGTH_BITS'(19661);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WHEEL_RADIUS = 2'd0,
    REG_SIDE_SPACING = 2'd1,
    REG_AXLE_SPACING = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SPEED_BITS-1:0] front_left_speed;
    logic signed [SPEED_BITS-1:0] front_right_speed;
    logic signed [SPEED_BITS-1:0] back_left_speed;
    logic signed [SPEED_BITS-1:0] back_right_speed;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic        [31:0] linear_speed;
    logic signed [31:0] rotation_rate;
    logic               spacing_zero;
    logic               saturated;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [SUM_W-1:0]       x_mag;
    logic [SUM_W-1:0]       y_mag;
    logic [SUM_W-1:0]       r_mag;
    logic                   x_neg;
    logic                   y_neg;
    logic                   r_neg;
    logic [LENGTH_BITS-1:0] radius;
    logic [SPC_W-1:0]       spacing;
    logic                   spacing_zero;
  } job_t;

  // sideband that rides along the root pipeline
  typedef struct packed {
    logic [31:0] vx_bits;
    logic [31:0] vy_bits;
    logic        r_neg;
    logic        r_ovf;
    logic        sat;
    logic        spacing_zero;
  } tail_t;

endpackage

// ----- design/mecanum_forward_kinematics.sv -----
// mecanum base forward kinematics: four signed q7.8 wheel speeds in, body
// velocity x/y, planar speed and yaw rate out, all in 2^-16 units and
// saturated to 32 bits. one item is taken per clock (start while busy is
// low); each result shows on out_data for exactly one cycle with out_valid
// high, and the receiver cannot stall it. the 32-stage yaw divider and the
// 32-stage square root run side by side. busy only rises if the short
// queue between the front and back ends fills, which a never-stalling back
// end prevents. radius and spacing registers are to be written through the
// cfg port only while the block is idle; the block does not enforce this.
// an item uses the values present when it was accepted
module mecanum_forward_kinematics (
  input  logic                                 clk,
  input  logic                                 rst_n,

  // input transfer: start && !busy
  input  logic                                 start,
  output logic                                 busy,
  input  mfk_pkg::in_item_t                    in_data,

  // result transfer, one-cycle strobe
  output logic                                 out_valid,
  output mfk_pkg::out_item_t                   out_data,

  // register write transfer: index 0 radius, 1 side, 2 axle
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mfk_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mfk_pkg::LENGTH_BITS-1:0]      cfg_data
);

  mfk_pkg::job_t front_job, back_job;
  logic          front_vld, back_vld;
  logic          fifo_almost_full;

  // front end: register file, wheel-speed sums, sign/magnitude split
  mfk_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .hold      (fifo_almost_full),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .job       (front_job),
    .job_vld   (front_vld)
  );

  // decoupling queue, leaves room for the item in flight in the front reg
  mfk_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (front_vld),
    .wr_data     (front_job),
    .almost_full (fifo_almost_full),
    .rd_vld      (back_vld),
    .rd_data     (back_job)
  );

  // back end: multiplies, rounding, clipping, divider and root pipelines
  mfk_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_vld   (back_vld),
    .job       (back_job),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- design/mfk_front.sv -----
module mfk_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  mfk_pkg::in_item_t                    in_data,
  input  logic                                 cfg_valid,
  input  logic [mfk_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mfk_pkg::LENGTH_BITS-1:0]      cfg_data,
  input  logic                                 hold,
  output logic                                 busy,
  output logic                                 cfg_ready,
  output mfk_pkg::job_t                        job,
  output logic                                 job_vld
);

  logic [mfk_pkg::LENGTH_BITS-1:0] radius_r, side_r, axle_r;
  logic signed [mfk_pkg::SUM_W-1:0] x_sum, y_sum, r_sum;
  logic signed [mfk_pkg::SUM_W-1:0] fl, fr, bl, br;
  logic [mfk_pkg::SPC_W-1:0] spacing;
  mfk_pkg::job_t job_nxt, job_r;
  logic job_vld_r;
  logic accept;

  assign busy      = hold;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~hold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= mfk_pkg::RADIUS_RST;
      side_r   <= mfk_pkg::SIDE_RST;
      axle_r   <= mfk_pkg::AXLE_RST;
    end else if (cfg_valid) begin
      case (mfk_pkg::cfg_reg_t'(cfg_index))
        mfk_pkg::REG_WHEEL_RADIUS: radius_r <= cfg_data;
        mfk_pkg::REG_SIDE_SPACING: side_r   <= cfg_data;
        mfk_pkg::REG_AXLE_SPACING: axle_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    fl = mfk_pkg::SUM_W'(in_data.front_left_speed);
    fr = mfk_pkg::SUM_W'(in_data.front_right_speed);
    bl = mfk_pkg::SUM_W'(in_data.back_left_speed);
    br = mfk_pkg::SUM_W'(in_data.back_right_speed);
    x_sum = fl + fr + bl + br;
    y_sum = fr + bl - fl - br;
    r_sum = fr + br - fl - bl;
    spacing = mfk_pkg::SPC_W'(axle_r) + mfk_pkg::SPC_W'(side_r);

    job_nxt.x_neg = x_sum[mfk_pkg::SUM_W-1];
    job_nxt.y_neg = y_sum[mfk_pkg::SUM_W-1];
    job_nxt.r_neg = r_sum[mfk_pkg::SUM_W-1];
    job_nxt.x_mag = $unsigned(job_nxt.x_neg ? -x_sum : x_sum);
    job_nxt.y_mag = $unsigned(job_nxt.y_neg ? -y_sum : y_sum);
    job_nxt.r_mag = $unsigned(job_nxt.r_neg ? -r_sum : r_sum);
    job_nxt.radius = radius_r;
    job_nxt.spacing = spacing;
    job_nxt.spacing_zero = (spacing == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_vld_r <= 1'b0;
    end else begin
      job_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_r <= job_nxt;
    end
  end

  assign job     = job_r;
  assign job_vld = job_vld_r;

endmodule

// ----- design/mfk_fifo.sv -----
module mfk_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mfk_pkg::job_t wr_data,
  output logic          almost_full,
  output logic          rd_vld,
  output mfk_pkg::job_t rd_data
);

  mfk_pkg::job_t mem [mfk_pkg::FIFO_DEPTH];
  logic [mfk_pkg::FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [mfk_pkg::FIFO_AW:0] count_r, count_nxt;
  logic pop;

  // the back end never stalls, so anything present is taken
  assign pop     = (count_r != '0);
  assign rd_vld  = pop;
  assign rd_data = mem[rd_ptr_r];
  assign almost_full = (count_r >= (mfk_pkg::FIFO_AW + 1)'(mfk_pkg::FIFO_DEPTH - 1));

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- design/mfk_div.sv -----
module mfk_div (
  input  logic                              clk,
  input  logic [mfk_pkg::PROD_W-1:0]        num,
  input  logic [mfk_pkg::DEN_W-1:0]         den,
  output logic [mfk_pkg::QUO_W-1:0]         quo
);

  // one quotient bit per stage, msb first
  logic [mfk_pkg::PROD_W-1:0] rem_q [1:mfk_pkg::STAGES];
  logic [mfk_pkg::DEN_W-1:0]  den_q [1:mfk_pkg::STAGES];
  logic [mfk_pkg::QUO_W-1:0]  quo_q [1:mfk_pkg::STAGES];

  for (genvar j = 0; j < mfk_pkg::STAGES; j++) begin : g_stage
    localparam int K = mfk_pkg::STAGES - 1 - j;
    logic [mfk_pkg::PROD_W-1:0] rem_in;
    logic [mfk_pkg::DEN_W-1:0]  den_in;
    logic [mfk_pkg::QUO_W-1:0]  quo_in;
    logic [mfk_pkg::WIDE_W-1:0] dsh, rem_w;
    logic                       take;

    if (j == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j];
      assign den_in = den_q[j];
      assign quo_in = quo_q[j];
    end

    assign dsh   = mfk_pkg::WIDE_W'(den_in) << K;
    assign rem_w = mfk_pkg::WIDE_W'(rem_in);
    assign take  = (rem_w >= dsh);

    always_ff @(posedge clk) begin
      rem_q[j+1] <= take ? mfk_pkg::PROD_W'(rem_w - dsh) : rem_in;
      den_q[j+1] <= den_in;
      quo_q[j+1] <= quo_in | (take ? (mfk_pkg::QUO_W'(1) << K) : '0);
    end
  end

  assign quo = quo_q[mfk_pkg::STAGES];

endmodule

// ----- design/mfk_sqrt.sv -----
module mfk_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  input  logic [mfk_pkg::PROD_W-1:0] radicand,
  input  mfk_pkg::tail_t             tail_in,
  output logic                       out_vld,
  output logic [31:0]                root,
  output mfk_pkg::tail_t             tail_out
);

  // digit-by-digit root, one result bit per stage
  logic [mfk_pkg::PROD_W-1:0] n_q   [1:mfk_pkg::STAGES];
  logic [mfk_pkg::PROD_W-1:0] res_q [1:mfk_pkg::STAGES];
  mfk_pkg::tail_t             tail_q [1:mfk_pkg::STAGES];
  logic [mfk_pkg::STAGES:1]   vld_r;

  for (genvar j = 0; j < mfk_pkg::STAGES; j++) begin : g_stage
    localparam int K = mfk_pkg::STAGES - 1 - j;
    logic [mfk_pkg::PROD_W-1:0] n_in, res_in, bitv;
    logic [mfk_pkg::PROD_W:0]   trial;
    mfk_pkg::tail_t             t_in;
    logic                       v_in;
    logic                       take;

    if (j == 0) begin : g_first
      assign n_in   = radicand;
      assign res_in = '0;
      assign t_in   = tail_in;
      assign v_in   = in_vld;
    end else begin : g_next
      assign n_in   = n_q[j];
      assign res_in = res_q[j];
      assign t_in   = tail_q[j];
      assign v_in   = vld_r[j];
    end

    assign bitv  = mfk_pkg::PROD_W'(1) << (2 * K);
    assign trial = (mfk_pkg::PROD_W + 1)'(res_in) + (mfk_pkg::PROD_W + 1)'(bitv);
    assign take  = ((mfk_pkg::PROD_W + 1)'(n_in) >= trial);

    always_ff @(posedge clk) begin
      n_q[j+1]    <= take ? n_in - trial[mfk_pkg::PROD_W-1:0] : n_in;
      res_q[j+1]  <= take ? (res_in >> 1) + bitv : res_in >> 1;
      tail_q[j+1] <= t_in;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else begin
        vld_r[j+1] <= v_in;
      end
    end
  end

  assign out_vld  = vld_r[mfk_pkg::STAGES];
  assign root     = res_q[mfk_pkg::STAGES][31:0];
  assign tail_out = tail_q[mfk_pkg::STAGES];

endmodule

// ----- design/mfk_back.sv -----
module mfk_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_vld,
  input  mfk_pkg::job_t      job,
  output logic               out_valid,
  output mfk_pkg::out_item_t out_data
);

  typedef struct packed {
    logic [31:0] mag;
    logic [31:0] bits;
    logic        sat;
  } lin_t;

  function automatic lin_t clip_term(input logic neg, input logic [32:0] mag);
    lin_t        r;
    logic [32:0] lim;
    lim = neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
    r.sat = (mag > lim);
    r.mag = r.sat ? lim[31:0] : mag[31:0];
    r.bits = neg ? (32'd0 - r.mag) : r.mag;
    return r;
  endfunction

  function automatic logic [32:0] round_term(input logic capped,
                                             input logic [mfk_pkg::PROD_W-1:0] p);
    logic [mfk_pkg::PROD_W:0] s;
    s = (mfk_pkg::PROD_W + 1)'(p) + (mfk_pkg::PROD_W + 1)'(33'h0_8000_0000);
    return capped ? 33'h0_FFFF_FFFF : s[mfk_pkg::PROD_W:32];
  endfunction

  // s1: radius products
  logic                       v1_r;
  logic [mfk_pkg::MAG_W-1:0]  mx1_r, my1_r, mr1_r;
  logic                       xn1_r, yn1_r, rn1_r, z1_r;
  logic [mfk_pkg::SPC_W-1:0]  sp1_r;

  // s2: product cap
  logic                       v2_r;
  logic [mfk_pkg::CAP_W-1:0]  mx2_r, my2_r, mr2_r;
  logic                       cx2_r, cy2_r, cr2_r;
  logic                       xn2_r, yn2_r, rn2_r, z2_r;
  logic [mfk_pkg::SPC_W-1:0]  sp2_r;

  // s3: partial products with pi
  logic                       v3_r;
  logic [mfk_pkg::LO_W-1:0]   lx3_r, ly3_r, lr3_r;
  logic [mfk_pkg::HI_W-1:0]   hx3_r, hy3_r, hr3_r;
  logic                       cx3_r, cy3_r, cr3_r;
  logic                       xn3_r, yn3_r, rn3_r, z3_r;
  logic [mfk_pkg::SPC_W-1:0]  sp3_r;

  // s4: full products
  logic                       v4_r;
  logic [mfk_pkg::PROD_W-1:0] px4_r, py4_r, pr4_r;
  logic                       cx4_r, cy4_r, cr4_r;
  logic                       xn4_r, yn4_r, rn4_r, z4_r;
  logic [mfk_pkg::SPC_W-1:0]  sp4_r;

  // s5: linear terms done, divider operands
  logic                       v5_r;
  lin_t                       lx5_r, ly5_r;
  logic [mfk_pkg::PROD_W-1:0] num5_r;
  logic [mfk_pkg::DEN_W-1:0]  den5_r;
  logic                       rsat5_r, rn5_r, z5_r;

  // s6: squares, quotient range check
  logic                       v6_r;
  logic [63:0]                sqx6_r, sqy6_r;
  logic [mfk_pkg::PROD_W-1:0] num6_r;
  logic [mfk_pkg::DEN_W-1:0]  den6_r;
  mfk_pkg::tail_t             tail6_r;

  // s7: sum of squares
  logic                       v7_r;
  logic [mfk_pkg::PROD_W-1:0] sum7_r;
  logic [mfk_pkg::PROD_W-1:0] num7_r;
  logic [mfk_pkg::DEN_W-1:0]  den7_r;
  mfk_pkg::tail_t             tail7_r;

  logic [mfk_pkg::QUO_W-1:0]  quo;
  logic [31:0]                root;
  logic                       root_vld;
  mfk_pkg::tail_t             tail_end;
  lin_t                       rot;
  logic [32:0]                rot_mag;
  mfk_pkg::out_item_t         out_nxt, out_r;
  logic                       out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0;
    end else begin
      v1_r <= job_vld; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
      v5_r <= v4_r; v6_r <= v5_r; v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    mx1_r <= mfk_pkg::MAG_W'(job.x_mag) * mfk_pkg::MAG_W'(job.radius);
    my1_r <= mfk_pkg::MAG_W'(job.y_mag) * mfk_pkg::MAG_W'(job.radius);
    mr1_r <= mfk_pkg::MAG_W'(job.r_mag) * mfk_pkg::MAG_W'(job.radius);
    xn1_r <= job.x_neg; yn1_r <= job.y_neg; rn1_r <= job.r_neg;
    z1_r  <= job.spacing_zero;
    sp1_r <= job.spacing;

    cx2_r <= ((mfk_pkg::EXT_W'(mx1_r) >> mfk_pkg::CAP_W) != '0);
    cy2_r <= ((mfk_pkg::EXT_W'(my1_r) >> mfk_pkg::CAP_W) != '0);
    cr2_r <= ((mfk_pkg::EXT_W'(mr1_r) >> mfk_pkg::CAP_W) != '0);
    mx2_r <= ((mfk_pkg::EXT_W'(mx1_r) >> mfk_pkg::CAP_W) != '0) ? '1 : mfk_pkg::CAP_W'(mx1_r);
    my2_r <= ((mfk_pkg::EXT_W'(my1_r) >> mfk_pkg::CAP_W) != '0) ? '1 : mfk_pkg::CAP_W'(my1_r);
    mr2_r <= ((mfk_pkg::EXT_W'(mr1_r) >> mfk_pkg::CAP_W) != '0) ? '1 : mfk_pkg::CAP_W'(mr1_r);
    xn2_r <= xn1_r; yn2_r <= yn1_r; rn2_r <= rn1_r; z2_r <= z1_r; sp2_r <= sp1_r;

    lx3_r <= mfk_pkg::LO_W'(mx2_r[mfk_pkg::SPLIT-1:0]) * mfk_pkg::LO_W'(mfk_pkg::PI_Q23);
    ly3_r <= mfk_pkg::LO_W'(my2_r[mfk_pkg::SPLIT-1:0]) * mfk_pkg::LO_W'(mfk_pkg::PI_Q23);
    lr3_r <= mfk_pkg::LO_W'(mr2_r[mfk_pkg::SPLIT-1:0]) * mfk_pkg::LO_W'(mfk_pkg::PI_Q23);
    hx3_r <= mfk_pkg::HI_W'(mx2_r[mfk_pkg::CAP_W-1:mfk_pkg::SPLIT])
             * mfk_pkg::HI_W'(mfk_pkg::PI_Q23);
    hy3_r <= mfk_pkg::HI_W'(my2_r[mfk_pkg::CAP_W-1:mfk_pkg::SPLIT])
             * mfk_pkg::HI_W'(mfk_pkg::PI_Q23);
    hr3_r <= mfk_pkg::HI_W'(mr2_r[mfk_pkg::CAP_W-1:mfk_pkg::SPLIT])
             * mfk_pkg::HI_W'(mfk_pkg::PI_Q23);
    cx3_r <= cx2_r; cy3_r <= cy2_r; cr3_r <= cr2_r;
    xn3_r <= xn2_r; yn3_r <= yn2_r; rn3_r <= rn2_r; z3_r <= z2_r; sp3_r <= sp2_r;

    px4_r <= (mfk_pkg::PROD_W'(hx3_r) << mfk_pkg::SPLIT) + mfk_pkg::PROD_W'(lx3_r);
    py4_r <= (mfk_pkg::PROD_W'(hy3_r) << mfk_pkg::SPLIT) + mfk_pkg::PROD_W'(ly3_r);
    pr4_r <= (mfk_pkg::PROD_W'(hr3_r) << mfk_pkg::SPLIT) + mfk_pkg::PROD_W'(lr3_r);
    cx4_r <= cx3_r; cy4_r <= cy3_r; cr4_r <= cr3_r;
    xn4_r <= xn3_r; yn4_r <= yn3_r; rn4_r <= rn3_r; z4_r <= z3_r; sp4_r <= sp3_r;

    lx5_r   <= clip_term(xn4_r, round_term(cx4_r, px4_r));
    ly5_r   <= clip_term(yn4_r, round_term(cy4_r, py4_r));
    num5_r  <= pr4_r + (mfk_pkg::PROD_W'(sp4_r) << 14);
    den5_r  <= mfk_pkg::DEN_W'(sp4_r) << 15;
    rsat5_r <= cr4_r & ~z4_r;
    rn5_r   <= rn4_r;
    z5_r    <= z4_r;

    sqx6_r <= 64'(lx5_r.mag) * 64'(lx5_r.mag);
    sqy6_r <= 64'(ly5_r.mag) * 64'(ly5_r.mag);
    num6_r <= num5_r;
    den6_r <= den5_r;
    tail6_r.vx_bits      <= lx5_r.bits;
    tail6_r.vy_bits      <= ly5_r.bits;
    tail6_r.r_neg        <= rn5_r;
    tail6_r.r_ovf        <= (mfk_pkg::WIDE_W'(num5_r)
                             >= (mfk_pkg::WIDE_W'(den5_r) << mfk_pkg::QUO_W));
    tail6_r.sat          <= lx5_r.sat | ly5_r.sat | rsat5_r;
    tail6_r.spacing_zero <= z5_r;

    sum7_r  <= sqx6_r + sqy6_r;
    num7_r  <= num6_r;
    den7_r  <= den6_r;
    tail7_r <= tail6_r;
  end

  mfk_div u_div (
    .clk (clk),
    .num (num7_r),
    .den (den7_r),
    .quo (quo)
  );

  mfk_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v7_r),
    .radicand (sum7_r),
    .tail_in  (tail7_r),
    .out_vld  (root_vld),
    .root     (root),
    .tail_out (tail_end)
  );

  always_comb begin
    rot_mag = tail_end.r_ovf ? 33'h0_FFFF_FFFF : 33'(quo);
    rot = clip_term(tail_end.r_neg, rot_mag);
    out_nxt.velocity_x    = tail_end.vx_bits;
    out_nxt.velocity_y    = tail_end.vy_bits;
    out_nxt.linear_speed  = root;
    out_nxt.rotation_rate = tail_end.spacing_zero ? 32'sd0 : rot.bits;
    out_nxt.spacing_zero  = tail_end.spacing_zero;
    out_nxt.saturated     = tail_end.sat | (rot.sat & ~tail_end.spacing_zero);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= root_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule
